// ===== hdl/refcounted_slot_allocator_assert.svh =====
// Assertion macros for the slot allocator checker.
// Depends on nothing; included by the checker file only.
`ifndef REFCOUNTED_SLOT_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rsa_pkg.sv =====
// Shared types and constants for the reference counted slot allocator.
// No dependencies; imported by the top level and its checker.
package rsa_pkg;

    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 16;
    localparam int CFG_W    = 6;

    localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = 6'd32;

    typedef enum logic [1:0] {
        ACT_ACQUIRE,
        ACT_RETAIN,
        ACT_RELEASE,
        ACT_INIT
    } action_t;

    typedef enum logic [2:0] {
        STS_OK,
        STS_EMPTY,
        STS_RANGE,
        STS_UNDER,
        STS_OVER
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

// ===== hdl/refcounted_slot_allocator.sv =====
// Reference counted slot allocator: free bitmap plus a count memory.
// Depends on rsa_pkg.

// An item is taken at an edge where start is high and busy is low. The count
// memory is read at that transfer edge into a read register, and in the
// next cycle, while busy is high, the count and the free bitmap are updated.
// The result appears on the result ports with done high for exactly one cycle
// right after that update cycle, and the receiver cannot stall it; a new item
// may be started in that same cycle, so a new item is taken only once the
// last one is through its update. Counts are cleared at reset and by the init
// action through per-slot valid flops, so there is no clearing pass. The cfg
// channel is always ready; it writes slot_count, which is applied only by init.
module refcounted_slot_allocator #(
    parameter int MAX_SLOTS  = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    action,
    input  logic [rsa_pkg::SLOT_W-1:0]    slot,
    output logic                          done,
    output logic [rsa_pkg::STATUS_W-1:0]  status,
    output logic [rsa_pkg::SLOT_W-1:0]    granted_slot,
    output logic [rsa_pkg::COUNT_W-1:0]   count_after,
    output logic                          slot_freed,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rsa_pkg::CFG_W-1:0]     cfg_data
);
    import rsa_pkg::*;

    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int MEM_DEPTH = 1 << IDX_W;

    // control state
    state_t                 state_reg, state_next;
    logic                   done_reg;
    logic [MAX_SLOTS-1:0]   free_bits_reg, free_bits_next;
    logic [MEM_DEPTH-1:0]   valid_reg, valid_next;
    logic [CFG_W-1:0]       active_count_reg, active_count_next;
    logic [CFG_W-1:0]       slot_count_reg;

    // request and result payload
    action_t                action_reg;
    logic [SLOT_W-1:0]      slot_reg;
    status_t                status_reg, status_next;
    logic [SLOT_W-1:0]      granted_reg, granted_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   freed_reg, freed_next;

    // count memory
    logic [COUNT_BITS-1:0]  count_mem [MEM_DEPTH];
    logic [COUNT_BITS-1:0]  rd_data_reg;
    logic                   mem_we;
    logic [IDX_W-1:0]       wr_addr;
    logic [COUNT_BITS-1:0]  wr_data;

    logic                   accept;
    logic [COUNT_BITS-1:0]  cnt, cnt_inc, cnt_dec;
    logic [MAX_SLOTS-1:0]   init_mask;
    logic [SLOT_W-1:0]      grant_idx;
    logic                   out_of_range;
    logic [COUNT_BITS+COUNT_W-1:0] cnt_wide, inc_wide, dec_wide;

    assign accept    = start && (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // next state
    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy         = (state_reg == S_EXEC);
        done         = done_reg;
        status       = status_reg;
        granted_slot = granted_reg;
        count_after  = count_reg;
        slot_freed   = freed_reg;
    end

    // lowest free slot
    always_comb
    begin
        grant_idx = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (free_bits_reg[i])
            begin
                grant_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            init_mask[i] = (CFG_W'(i) < slot_count_reg);
        end
    end

    // an entry not written since the last init reads as zero
    assign cnt          = valid_reg[slot_reg[IDX_W-1:0]] ? rd_data_reg : '0;
    assign cnt_inc      = cnt + 1'b1;
    assign cnt_dec      = cnt - 1'b1;
    assign cnt_wide     = {{COUNT_W{1'b0}}, cnt};
    assign inc_wide     = {{COUNT_W{1'b0}}, cnt_inc};
    assign dec_wide     = {{COUNT_W{1'b0}}, cnt_dec};
    assign out_of_range = ({1'b0, slot_reg} >= active_count_reg);

    // read-modify-write of the addressed slot
    always_comb
    begin
        free_bits_next    = free_bits_reg;
        valid_next        = valid_reg;
        active_count_next = active_count_reg;
        status_next       = STS_OK;
        granted_next      = '0;
        count_next        = '0;
        freed_next        = 1'b0;
        mem_we            = 1'b0;
        wr_addr           = slot_reg[IDX_W-1:0];
        wr_data           = cnt_inc;

        if (state_reg == S_EXEC)
        begin
            case (action_reg)
                ACT_INIT:
                begin
                    if ((slot_count_reg == '0) || (slot_count_reg > CFG_W'(MAX_SLOTS)))
                    begin
                        status_next = STS_RANGE;
                    end
                    else
                    begin
                        active_count_next = slot_count_reg;
                        free_bits_next    = init_mask;
                        valid_next        = '0;
                    end
                end
                ACT_ACQUIRE:
                begin
                    if (free_bits_reg == '0)
                    begin
                        status_next = STS_EMPTY;
                    end
                    else
                    begin
                        free_bits_next[grant_idx] = 1'b0;
                        valid_next[grant_idx[IDX_W-1:0]] = 1'b1;
                        mem_we       = 1'b1;
                        wr_addr      = grant_idx[IDX_W-1:0];
                        wr_data      = COUNT_BITS'(1);
                        granted_next = grant_idx;
                        count_next   = COUNT_W'(1);
                    end
                end
                ACT_RETAIN:
                begin
                    if (out_of_range)
                    begin
                        status_next = STS_RANGE;
                    end
                    else if (cnt == '1)
                    begin
                        status_next = STS_OVER;
                        count_next  = cnt_wide[COUNT_W-1:0];
                    end
                    else
                    begin
                        valid_next[slot_reg[IDX_W-1:0]] = 1'b1;
                        mem_we     = 1'b1;
                        wr_data    = cnt_inc;
                        count_next = inc_wide[COUNT_W-1:0];
                    end
                end
                ACT_RELEASE:
                begin
                    if (out_of_range)
                    begin
                        status_next = STS_RANGE;
                    end
                    else if (cnt == '0)
                    begin
                        status_next = STS_UNDER;
                    end
                    else
                    begin
                        valid_next[slot_reg[IDX_W-1:0]] = 1'b1;
                        mem_we  = 1'b1;
                        wr_data = cnt_dec;
                        if (cnt_dec == '0)
                        begin
                            free_bits_next[slot_reg] = 1'b1;
                            freed_next = 1'b1;
                        end
                        else
                        begin
                            count_next = dec_wide[COUNT_W-1:0];
                        end
                    end
                end
                default:
                begin
                    status_next = STS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            done_reg         <= 1'b0;
            free_bits_reg    <= '1;
            valid_reg        <= '0;
            active_count_reg <= CFG_W'(MAX_SLOTS);
            slot_count_reg   <= SLOT_COUNT_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            done_reg         <= (state_reg == S_EXEC);
            free_bits_reg    <= free_bits_next;
            valid_reg        <= valid_next;
            active_count_reg <= active_count_next;
            if (cfg_valid && cfg_ready)
            begin
                slot_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action_t'(action);
            slot_reg   <= slot;
        end
        if (state_reg == S_EXEC)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            count_reg   <= count_next;
            freed_reg   <= freed_next;
        end
    end

    // count memory: read at transfer, write back during the update cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[wr_addr] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg <= count_mem[slot[IDX_W-1:0]];
        end
    end

endmodule

// ===== hdl/rsa_checker.sv =====
// Port-level checker for the slot allocator, bound to the top level.
// Depends on rsa_pkg and refcounted_slot_allocator_assert.svh.
`include "refcounted_slot_allocator_assert.svh"

module rsa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [1:0]                    action,
    input logic [rsa_pkg::SLOT_W-1:0]    slot,
    input logic                          done,
    input logic [rsa_pkg::STATUS_W-1:0]  status,
    input logic [rsa_pkg::SLOT_W-1:0]    granted_slot,
    input logic [rsa_pkg::COUNT_W-1:0]   count_after,
    input logic                          slot_freed,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [rsa_pkg::CFG_W-1:0]     cfg_data
);
    import rsa_pkg::*;

    // the update cycle lasts one cycle and is followed by its result
    `RSA_ASSERT_NEXT(a_busy_then_done, clk, rst_n, busy, done && !busy, "update cycle did not produce a result")
    // no result without a preceding update cycle
    `RSA_ASSERT_NOW(a_done_after_busy, clk, rst_n, done, $past(busy), "result strobe without a request")
    // a transfer starts the update cycle
    `RSA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted request did not start")
    // a freed slot reports success and a zero count
    `RSA_ASSERT_NOW(a_freed_ok, clk, rst_n, done && slot_freed, (status == STS_OK) && (count_after == '0), "freed slot with bad status or count")
    // a nonzero grant comes from a successful acquire
    `RSA_ASSERT_NOW(a_grant_ok, clk, rst_n, done && (granted_slot != '0), (status == STS_OK) && (count_after == 16'd1), "grant without count of one")

endmodule

bind refcounted_slot_allocator rsa_checker u_rsa_checker (.*);
